// ===== src/text_console_writer_defines.svh =====
// Assertion macros used by the console writer top level.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_console_writer: check failed");

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_console_writer: check failed");

`endif

// ===== src/tcw_pkg.sv =====
// Shared constants and controller/datapath types of the text console writer.
package tcw_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int POS_W     = 11;
  localparam int CELL_W    = 16;
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET     = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET     = 4'h0;

  typedef struct packed {
    logic capture;
    logic div;
    logic col;
    logic phys;
    logic addr;
    logic put_write;
    logic mem_read;
    logic sel;
    logic clear;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } stat_t;

endpackage

// ===== src/tcw_req_if.sv =====
// Request channel of the text console writer.
interface tcw_req_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::OPCODE_W-1:0] opcode;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::INDEX_W-1:0]  read_index;

  modport source (output valid, opcode, char_code, read_index, input ready);
  modport sink (input valid, opcode, char_code, read_index, output ready);
endinterface

// ===== src/tcw_rsp_if.sv =====
// Response channel of the text console writer.
interface tcw_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::POS_W-1:0]  cursor_pos;
  logic [tcw_pkg::CELL_W-1:0] cell_data;

  modport source (output valid, cursor_pos, cell_data, input ready);
  modport sink (input valid, cursor_pos, cell_data, output ready);
endinterface

// ===== src/tcw_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
module tcw_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [tcw_pkg::OPCODE_W-1:0] opcode,
  output logic                         in_ready,
  input  tcw_pkg::stat_t               stat,
  output tcw_pkg::cmd_t                cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDIV  = 4'd1;
  localparam logic [3:0] S_RCOL  = 4'd2;
  localparam logic [3:0] S_PHYS  = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_WRITE = 4'd5;
  localparam logic [3:0] S_RMEM  = 4'd6;
  localparam logic [3:0] S_RSEL  = 4'd7;
  localparam logic [3:0] S_CLEAR = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [tcw_pkg::OPCODE_W-1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= opcode;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (opcode)
            tcw_pkg::OP_PUT:   state_next = S_PHYS;
            tcw_pkg::OP_CLEAR: state_next = S_CLEAR;
            tcw_pkg::OP_READ:  state_next = S_RDIV;
            default:           state_next = S_DONE;
          endcase
        end
      end
      S_RDIV: begin
        cmd.div    = 1'b1;
        state_next = S_RCOL;
      end
      S_RCOL: begin
        cmd.col    = 1'b1;
        state_next = S_PHYS;
      end
      S_PHYS: begin
        cmd.phys   = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = (op == tcw_pkg::OP_PUT) ? S_WRITE : S_RMEM;
      end
      S_WRITE: begin
        cmd.put_write = 1'b1;
        state_next    = S_DONE;
      end
      S_RMEM: begin
        cmd.mem_read = 1'b1;
        state_next   = S_RSEL;
      end
      S_RSEL: begin
        cmd.sel    = 1'b1;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/tcw_datapath.sv =====
// Datapath: screen memory, per-row fill counts, cursor, scroll base and result register.
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tcw_pkg::cmd_t                 cmd,
  output tcw_pkg::stat_t                stat,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]   read_index,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::POS_W-1:0]     cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data
);

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int FILL_W   = $clog2(COLUMNS + 1);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int LIN_W    = $clog2(CELLS + 1);
  localparam int IDX_W    = tcw_pkg::INDEX_W;
  localparam int POS_W    = tcw_pkg::POS_W;
  localparam int CHAR_W   = tcw_pkg::CHAR_W;
  localparam int CELL_W   = tcw_pkg::CELL_W;
  localparam int COLOR_W  = tcw_pkg::COLOR_W;
  localparam int SHIFT    = IDX_W + COL_W;
  localparam int RECIP    = ((1 << SHIFT) + COLUMNS - 1) / COLUMNS;
  localparam int RECIP_W  = SHIFT + 1;
  localparam int PROD_W   = IDX_W + RECIP_W;
  localparam int BOTTOM_LIN = (ROWS - 1) * COLUMNS;

  // Color pair of a blank cell, background in the upper half.
  logic [COLOR_W-1:0]   fg;
  logic [COLOR_W-1:0]   bg;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;
  logic [LIN_W-1:0]     cur_lin;
  logic [ROW_W-1:0]     base;
  logic [FILL_W-1:0]    fill [ROWS];
  logic [2*COLOR_W-1:0] blank [ROWS];
  logic [CELL_W-1:0]    mem [CELLS];
  logic [CELL_W-1:0]    rd_q;

  logic [CHAR_W-1:0]    char_q;
  logic [IDX_W-1:0]     ridx_q;
  logic [IDX_W-1:0]     quot;
  logic                 in_range;
  logic [ROW_W-1:0]     work_row;
  logic [COL_W-1:0]     work_col;
  logic [ROW_W-1:0]     work_phys;
  logic [ADDR_W-1:0]    work_addr;
  logic                 hit;
  logic [2*COLOR_W-1:0] blank_sel;
  logic [CELL_W-1:0]    result_data;

  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     quot_cols;
  logic [IDX_W-1:0]     col_rem;
  logic                 range_ok;
  logic [ROW_W:0]       row_sum;
  logic [ROW_W-1:0]     phys_next;
  logic [ADDR_W-1:0]    addr_next;

  logic                 is_nl;
  logic [COL_W:0]       col_inc;
  logic                 wrap;
  logic [ROW_W:0]       row_inc;
  logic                 scroll;
  logic [ROW_W-1:0]     base_inc;
  logic [LIN_W-1:0]     lin_nl;
  logic [CELL_W-1:0]    put_cell;

  // Linear index to row and column by reciprocal multiplication; exact for every index.
  assign prod      = PROD_W'(ridx_q) * PROD_W'(RECIP);
  assign quot_cols = IDX_W'(quot * IDX_W'(COLUMNS));
  assign col_rem   = ridx_q - quot_cols;
  assign range_ok  = 32'(ridx_q) < CELLS;

  assign row_sum   = {1'b0, work_row} + {1'b0, base};
  assign phys_next = (row_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W + 1)'(ROWS))
                                                     : row_sum[ROW_W-1:0];
  assign addr_next = ADDR_W'(ADDR_W'(work_phys) * ADDR_W'(COLUMNS)) + ADDR_W'(work_col);

  assign is_nl    = (char_q == tcw_pkg::NEWLINE_CODE);
  assign col_inc  = {1'b0, cur_col} + (COL_W + 1)'(1);
  assign wrap     = (col_inc == (COL_W + 1)'(COLUMNS));
  assign row_inc  = {1'b0, cur_row} + (ROW_W + 1)'(1);
  assign scroll   = (is_nl || wrap) && (row_inc == (ROW_W + 1)'(ROWS));
  assign base_inc = (base == ROW_W'(ROWS - 1)) ? '0 : ROW_W'(base + ROW_W'(1));
  assign lin_nl   = cur_lin - LIN_W'(cur_col) + LIN_W'(COLUMNS);
  assign put_cell = {bg, fg, char_q};

  assign stat.out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg        <= tcw_pkg::FG_RESET;
      bg        <= tcw_pkg::BG_RESET;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_lin   <= '0;
      base      <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        fill[r]  <= '0;
        blank[r] <= {tcw_pkg::BG_RESET, tcw_pkg::FG_RESET};
      end
    end else begin
      if (cfg_write) begin
        if (cfg_index == tcw_pkg::REG_FG) begin
          fg <= cfg_data;
        end else if (cfg_index == tcw_pkg::REG_BG) begin
          bg <= cfg_data;
        end
      end
      if (cmd.clear) begin
        cur_col <= '0;
        cur_row <= '0;
        cur_lin <= '0;
        base    <= '0;
        for (int r = 0; r < ROWS; r++) begin
          fill[r]  <= '0;
          blank[r] <= {bg, fg};
        end
      end
      if (cmd.put_write) begin
        if (!is_nl) begin
          fill[work_phys] <= FILL_W'(col_inc);
        end
        // The oldest row becomes the new, blank bottom row.
        if (scroll) begin
          cur_col     <= '0;
          cur_row     <= ROW_W'(ROWS - 1);
          cur_lin     <= LIN_W'(BOTTOM_LIN);
          base        <= base_inc;
          fill[base]  <= '0;
          blank[base] <= {bg, fg};
        end else if (is_nl) begin
          cur_col <= '0;
          cur_row <= row_inc[ROW_W-1:0];
          cur_lin <= lin_nl;
        end else begin
          cur_lin <= cur_lin + LIN_W'(1);
          if (wrap) begin
            cur_col <= '0;
            cur_row <= row_inc[ROW_W-1:0];
          end else begin
            cur_col <= col_inc[COL_W-1:0];
          end
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_q      <= char_code;
      ridx_q      <= read_index;
      work_row    <= cur_row;
      work_col    <= cur_col;
      result_data <= '0;
    end
    if (cmd.div) begin
      quot <= prod[SHIFT +: IDX_W];
    end
    if (cmd.col) begin
      in_range <= range_ok;
      work_row <= range_ok ? quot[ROW_W-1:0] : '0;
      work_col <= range_ok ? col_rem[COL_W-1:0] : '0;
    end
    if (cmd.phys) begin
      work_phys <= phys_next;
    end
    if (cmd.addr) begin
      work_addr <= addr_next;
      hit       <= FILL_W'(work_col) < fill[work_phys];
      blank_sel <= blank[work_phys];
    end
    if (cmd.sel) begin
      if (!in_range) begin
        result_data <= '0;
      end else if (hit) begin
        result_data <= rd_q;
      end else begin
        result_data <= {blank_sel, tcw_pkg::BLANK_CODE};
      end
    end
    if (cmd.load_out) begin
      cursor_pos <= POS_W'(cur_lin);
      cell_data  <= result_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_write && !is_nl) begin
      mem[work_addr] <= put_cell;
    end
    if (cmd.mem_read) begin
      rd_q <= mem[work_addr];
    end
  end

endmodule

// ===== src/text_console_writer.sv =====
// Top level of the text console writer: controller, datapath and checks.
//
//   channel  direction  handshake          payload
//   req      in         valid / ready      opcode, char_code, read_index
//   rsp      out        valid / ready      cursor_pos, cell_data
//   cfg      in         cfg_write only     cfg_index, cfg_data
//
// Each item runs through its states before the next is accepted. Puts and
// reads share the address path (row rotation, then row times COLUMNS) and the
// single screen memory port; a read adds two division steps, a clear has one
// clear step. Scroll and clear take no sweep: per-row fill counts and blank
// colors mark unwritten cells, so reset needs no sweep of the screen memory.
// A held result in rsp stalls only the final step of the next item.
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  tcw_req_if.sink                       req,
  tcw_rsp_if.source                     rsp,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);

  tcw_pkg::cmd_t  cmd;
  tcw_pkg::stat_t stat;
  logic           in_ready;

  assign req.ready = in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .opcode   (req.opcode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .char_code  (req.char_code),
    .read_index (req.read_index),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .cursor_pos (rsp.cursor_pos),
    .cell_data  (rsp.cell_data)
  );

  `TCW_ASSERT_NEXT(a_accept_then_busy, clk, rst, req.valid && req.ready, !req.ready)
  `TCW_ASSERT_IMP(a_load_into_free_slot, clk, rst, cmd.load_out, !stat.out_stall)
  `TCW_ASSERT_IMP(a_cursor_on_screen, clk, rst, rsp.valid, 32'(rsp.cursor_pos) < ROWS * COLUMNS)

endmodule
